### design/ffa_pkg.sv
`timescale 1ns / 1ps

package ffa_pkg;

  localparam int FREE_ENTRIES    = 16;
  localparam int USED_ENTRIES    = 16;
  localparam int HEADER_BYTES    = 16;
  // paragraph and grain are powers of two, rounding is done with masks
  localparam int PARAGRAPH_BYTES = 16;
  localparam int ALLOC_GRAIN     = 16;

  localparam int FI_W  = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
  localparam int UI_W  = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;
  localparam int FC_W  = $clog2(FREE_ENTRIES + 1);
  localparam int UC_W  = $clog2(USED_ENTRIES + 1);
  localparam int IDX_W = (FC_W > UC_W) ? FC_W : UC_W;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLE_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLE_END   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_END    = 2'd3;

  localparam logic [1:0] MODE_INIT  = 2'd0;
  localparam logic [1:0] MODE_ALLOC = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD     = 3'd1;
  localparam logic [2:0] ST_NOFIT   = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_INIT,
    OP_A_STEP,
    OP_A_TAKE,
    OP_U_STEP,
    OP_U_HIT,
    OP_F_STEP,
    OP_F_STOP,
    OP_F_CHECK,
    OP_F_APPLY
  } dp_op_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic signed [31:0] request_bytes;
    logic [31:0]       block_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] data_address;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    dp_op_e     op;
    logic       set_stat;
    logic [2:0] stat;
    logic       load_out;
  } ffa_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       bad_size;
    logic       used_full;
    logic       a_end;
    logic       a_fit;
    logic       u_end;
    logic       u_hit;
    logic       f_adv;
    logic       f_full;
  } ffa_stat_t;

endpackage

### design/ffa_ctrl.sv
`timescale 1ns / 1ps

module ffa_ctrl import ffa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  ffa_stat_t stat_i,
  output ffa_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_A_SCAN  = 4'd2;
  localparam logic [3:0] S_A_TAKE  = 4'd3;
  localparam logic [3:0] S_U_SCAN  = 4'd4;
  localparam logic [3:0] S_F_SCAN  = 4'd5;
  localparam logic [3:0] S_F_CHECK = 4'd6;
  localparam logic [3:0] S_F_APPLY = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d      = state_q;
    ovalid_d     = ovalid_q;
    cmd_o        = '0;
    cmd_o.op     = OP_NONE;
    cmd_o.stat   = ST_OK;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.mode)
          MODE_INIT: begin
            cmd_o.op       = OP_INIT;
            cmd_o.set_stat = 1'b1;
            cmd_o.stat     = ST_OK;
            state_d        = S_DONE;
          end
          MODE_ALLOC: begin
            if (stat_i.bad_size) begin
              cmd_o.set_stat = 1'b1;
              cmd_o.stat     = ST_BAD;
              state_d        = S_DONE;
            end else if (stat_i.used_full) begin
              cmd_o.set_stat = 1'b1;
              cmd_o.stat     = ST_FULL;
              state_d        = S_DONE;
            end else begin
              state_d = S_A_SCAN;
            end
          end
          MODE_FREE: state_d = S_U_SCAN;
          default: begin
            cmd_o.set_stat = 1'b1;
            cmd_o.stat     = ST_OK;
            state_d        = S_DONE;
          end
        endcase
      end
      S_A_SCAN: begin
        if (stat_i.a_end) begin
          cmd_o.set_stat = 1'b1;
          cmd_o.stat     = ST_NOFIT;
          state_d        = S_DONE;
        end else if (stat_i.a_fit) begin
          state_d = S_A_TAKE;
        end else begin
          cmd_o.op = OP_A_STEP;
        end
      end
      S_A_TAKE: begin
        cmd_o.op       = OP_A_TAKE;
        cmd_o.set_stat = 1'b1;
        cmd_o.stat     = ST_OK;
        state_d        = S_DONE;
      end
      S_U_SCAN: begin
        if (stat_i.u_end) begin
          cmd_o.set_stat = 1'b1;
          cmd_o.stat     = ST_UNKNOWN;
          state_d        = S_DONE;
        end else if (stat_i.u_hit) begin
          cmd_o.op = OP_U_HIT;
          state_d  = S_F_SCAN;
        end else begin
          cmd_o.op = OP_U_STEP;
        end
      end
      S_F_SCAN: begin
        if (stat_i.f_adv) begin
          cmd_o.op = OP_F_STEP;
        end else begin
          cmd_o.op = OP_F_STOP;
          state_d  = S_F_CHECK;
        end
      end
      S_F_CHECK: begin
        cmd_o.op = OP_F_CHECK;
        state_d  = S_F_APPLY;
      end
      S_F_APPLY: begin
        cmd_o.set_stat = 1'b1;
        if (stat_i.f_full) begin
          cmd_o.stat = ST_FULL;
        end else begin
          cmd_o.op   = OP_F_APPLY;
          cmd_o.stat = ST_OK;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        // output register free or draining this cycle
        if (!ovalid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

### design/ffa_datapath.sv
`timescale 1ns / 1ps

module ffa_datapath import ffa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  in_item_t             in_data_i,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  ffa_cmd_t             cmd_i,
  output ffa_stat_t            stat_o,
  output out_item_t            out_data_o
);

  localparam logic [31:0] HDR32   = 32'(HEADER_BYTES);
  localparam logic [31:0] PMASK32 = ~(32'(PARAGRAPH_BYTES) - 32'd1);
  localparam logic [32:0] GMASK33 = ~(33'(ALLOC_GRAIN) - 33'd1);

  function automatic logic [31:0] sat32(input logic [33:0] v);
    sat32 = (v > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  logic [31:0] heap_start_q, hole_start_q, hole_end_q, mem_end_q;

  logic [31:0] free_base_q [FREE_ENTRIES];
  logic [31:0] free_len_q  [FREE_ENTRIES];
  logic [31:0] used_base_q [USED_ENTRIES];
  logic [31:0] used_len_q  [USED_ENTRIES];
  logic [FC_W-1:0] free_cnt_q;
  logic [UC_W-1:0] used_cnt_q;

  logic [IDX_W-1:0] idx_q;
  logic [1:0]       mode_q;
  logic [31:0]      req_q, blk_q;
  logic [32:0]      amount_q;
  logic [31:0]      hb_q, hl_q, pb_q, pl_q, nb_q, nl_q;
  logic [UI_W-1:0]  j_q;
  logic             has_prev_q, next_ok_q, padj_q, nadj_q;
  logic [31:0]      res_addr_q;
  logic [2:0]       res_stat_q;
  out_item_t        out_q;

  logic [FI_W-1:0] fidx, fidx_m1;
  logic [UI_W-1:0] uidx, ucnt_idx;
  logic [31:0]     fb_rd, fl_rd, ub_rd, ul_rd;
  logic            a_end, split;

  assign fidx     = idx_q[FI_W-1:0];
  assign fidx_m1  = fidx - FI_W'(1);
  assign uidx     = idx_q[UI_W-1:0];
  assign ucnt_idx = used_cnt_q[UI_W-1:0];
  assign fb_rd    = free_base_q[fidx];
  assign fl_rd    = free_len_q[fidx];
  assign ub_rd    = used_base_q[uidx];
  assign ul_rd    = used_len_q[uidx];

  assign a_end = idx_q >= IDX_W'(free_cnt_q);
  assign split = {2'b00, fl_rd} > ({1'b0, amount_q} + 34'(HEADER_BYTES));

  always_comb begin
    stat_o           = '0;
    stat_o.mode      = mode_q;
    stat_o.bad_size  = (req_q == 32'd0) || req_q[31];
    stat_o.used_full = used_cnt_q >= UC_W'(USED_ENTRIES);
    stat_o.a_end     = a_end;
    stat_o.a_fit     = {1'b0, fl_rd} >= amount_q;
    stat_o.u_end     = idx_q >= IDX_W'(used_cnt_q);
    stat_o.u_hit     = (ub_rd + HDR32) == blk_q;
    stat_o.f_adv     = !a_end && (fb_rd <= hb_q);
    stat_o.f_full    = !padj_q && !nadj_q && (free_cnt_q >= FC_W'(FREE_ENTRIES));
  end

  // init extents
  logic [31:0] b0, l0, e1l, ib0, il0, ib1, il1;
  logic        v0, v1, iswap, imerge;
  always_comb begin
    b0     = heap_start_q & PMASK32;
    v0     = hole_start_q > b0;
    l0     = hole_start_q - b0;
    v1     = mem_end_q > hole_end_q;
    e1l    = mem_end_q - hole_end_q;
    iswap  = v0 && v1 && (hole_end_q < b0);
    ib0    = b0;
    il0    = l0;
    ib1    = hole_end_q;
    il1    = e1l;
    if (iswap || !v0) begin
      ib0 = hole_end_q;
      il0 = e1l;
      ib1 = b0;
      il1 = l0;
    end
    imerge = v0 && v1 && (({1'b0, ib0} + {1'b0, il0}) == {1'b0, ib1});
  end

  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_start_q <= 32'd262144;
      hole_start_q <= 32'd655360;
      hole_end_q   <= 32'd1646592;
      mem_end_q    <= 32'd4194304;
      free_cnt_q   <= '0;
      used_cnt_q   <= '0;
      idx_q        <= '0;
      mode_q       <= MODE_NOP;
      has_prev_q   <= 1'b0;
      next_ok_q    <= 1'b0;
      padj_q       <= 1'b0;
      nadj_q       <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_HEAP_START: heap_start_q <= cfg_data_i;
          REG_HOLE_START: hole_start_q <= cfg_data_i;
          REG_HOLE_END:   hole_end_q   <= cfg_data_i;
          REG_MEM_END:    mem_end_q    <= cfg_data_i;
          default: ;
        endcase
      end
      case (cmd_i.op)
        OP_LATCH: begin
          mode_q     <= in_data_i.mode;
          req_q      <= in_data_i.request_bytes;
          blk_q      <= in_data_i.block_address;
          amount_q   <= (({1'b0, in_data_i.request_bytes} + 33'(ALLOC_GRAIN - 1)) & GMASK33)
                        + 33'(HEADER_BYTES);
          idx_q      <= '0;
          has_prev_q <= 1'b0;
          res_addr_q <= 32'd0;
        end
        OP_INIT: begin
          free_base_q[0] <= ib0;
          free_len_q[0]  <= imerge ? sat32({2'b00, il0} + {2'b00, il1}) : il0;
          free_base_q[1] <= ib1;
          free_len_q[1]  <= il1;
          free_cnt_q     <= imerge ? FC_W'(1) : FC_W'({1'b0, v0} + {1'b0, v1});
          used_cnt_q     <= '0;
        end
        OP_A_STEP: idx_q <= idx_q + IDX_W'(1);
        OP_A_TAKE: begin
          if (split) begin
            free_base_q[fidx] <= fb_rd + amount_q[31:0];
            free_len_q[fidx]  <= fl_rd - amount_q[31:0];
          end else begin
            for (int k = 0; k < FREE_ENTRIES - 1; k++) begin
              if (FI_W'(k) >= fidx) begin
                free_base_q[k] <= free_base_q[k+1];
                free_len_q[k]  <= free_len_q[k+1];
              end
            end
            free_cnt_q <= free_cnt_q - FC_W'(1);
          end
          used_base_q[ucnt_idx] <= fb_rd;
          used_len_q[ucnt_idx]  <= split ? amount_q[31:0] : fl_rd;
          used_cnt_q            <= used_cnt_q + UC_W'(1);
          res_addr_q            <= fb_rd + HDR32;
        end
        OP_U_STEP: idx_q <= idx_q + IDX_W'(1);
        OP_U_HIT: begin
          hb_q  <= ub_rd;
          hl_q  <= ul_rd;
          j_q   <= uidx;
          idx_q <= '0;
        end
        OP_F_STEP: begin
          pb_q       <= fb_rd;
          pl_q       <= fl_rd;
          has_prev_q <= 1'b1;
          idx_q      <= idx_q + IDX_W'(1);
        end
        OP_F_STOP: begin
          nb_q      <= fb_rd;
          nl_q      <= fl_rd;
          next_ok_q <= !a_end;
        end
        OP_F_CHECK: begin
          padj_q <= has_prev_q && (({1'b0, pb_q} + {1'b0, pl_q}) == {1'b0, hb_q});
          nadj_q <= next_ok_q && (({1'b0, hb_q} + {1'b0, hl_q}) == {1'b0, nb_q});
        end
        OP_F_APPLY: begin
          for (int k = 0; k < USED_ENTRIES - 1; k++) begin
            if (UI_W'(k) >= j_q) begin
              used_base_q[k] <= used_base_q[k+1];
              used_len_q[k]  <= used_len_q[k+1];
            end
          end
          used_cnt_q <= used_cnt_q - UC_W'(1);
          if (padj_q && nadj_q) begin
            for (int k = 0; k < FREE_ENTRIES - 1; k++) begin
              if (FI_W'(k) >= fidx) begin
                free_base_q[k] <= free_base_q[k+1];
                free_len_q[k]  <= free_len_q[k+1];
              end
            end
            free_len_q[fidx_m1] <= sat32({2'b00, pl_q} + {2'b00, hl_q} + {2'b00, nl_q});
            free_cnt_q          <= free_cnt_q - FC_W'(1);
          end else if (padj_q) begin
            free_len_q[fidx_m1] <= sat32({2'b00, pl_q} + {2'b00, hl_q});
          end else if (nadj_q) begin
            free_base_q[fidx] <= hb_q;
            free_len_q[fidx]  <= sat32({2'b00, nl_q} + {2'b00, hl_q});
          end else begin
            // open a slot at the insertion point
            for (int k = 1; k < FREE_ENTRIES; k++) begin
              if (FI_W'(k) > fidx) begin
                free_base_q[k] <= free_base_q[k-1];
                free_len_q[k]  <= free_len_q[k-1];
              end
            end
            free_base_q[fidx] <= hb_q;
            free_len_q[fidx]  <= hl_q;
            free_cnt_q        <= free_cnt_q + FC_W'(1);
          end
        end
        default: ;
      endcase
      if (cmd_i.set_stat) res_stat_q <= cmd_i.stat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.data_address <= res_addr_q;
      out_q.status       <= res_stat_q;
    end
  end

endmodule

### design/first_fit_extent_allocator.sv
`timescale 1ns / 1ps
// Channel    Direction  Handshake          Payload
// in         input      valid / stall      in_item_t  (mode, request_bytes, block_address)
// out        output     valid / stall      out_item_t (data_address, status)
// cfg        input      valid / ready      index (2 bits), 32-bit data
//
// One request at a time: init, no-op, bad-size and used-table-full rejects skip the
// scans; allocate walks the free table, and free walks the used table and then the
// free table, in one-entry-per-cycle scans.
// A finished result waits in the output register while the next request is taken;
// a second result holds in the last state, with the input stalled, until it drains.
// Reset empties both tables; cfg is always ready.

module first_fit_extent_allocator import ffa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  ffa_cmd_t  cmd;
  ffa_stat_t stat;

  assign cfg_ready_o = 1'b1;

  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ffa_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule
